@@ design/int_key_value_table_defines.svh @@
// Assertion macros shared by the key/value table checker.
`ifndef INT_KEY_VALUE_TABLE_DEFINES_SVH
`define INT_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define IKVT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IKVT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ikvt_pkg.sv @@
// Shared types and codes for the key/value table.
package ikvt_pkg;

    typedef enum logic [1:0] {
        REQ_PUT    = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req_type;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load_req;   // capture request, clear index and hit
        logic rd_scan;    // read entry at index
        logic set_hit;    // key matched at index
        logic inc_idx;
        logic decide;     // latch read value and full flag for the result
        logic wr_value;   // overwrite value at index
        logic wr_append;  // write pair at count, count up
        logic rd_shift;   // read entry at index + 1
        logic wr_shift;   // move read entry down to index
        logic dec_cnt;
        logic load_out;   // load the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic       idx_at_count;
        logic       key_match;
        logic       shift_last;
        logic       table_full;
        logic       hit;
        logic       out_free;
        logic [1:0] req_type;
    } t_dp_sts;

endpackage

@@ design/ikvt_datapath.sv @@
// Datapath: pair memories, request registers, counters and output register.
module ikvt_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ikvt_pkg::t_dp_cmd  i_cmd,
    output ikvt_pkg::t_dp_sts  o_sts,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic               o_found,
    output logic signed [31:0] o_read_value,
    output logic               o_status,
    output logic [4:0]         o_entry_count
);
    import ikvt_pkg::*;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic signed [31:0] r_key_mem [CAPACITY];
    logic signed [31:0] r_val_mem [CAPACITY];

    logic [1:0]         r_req_type;
    logic signed [31:0] r_key;
    logic signed [31:0] r_value;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_hit;
    logic signed [31:0] r_key_q;
    logic signed [31:0] r_val_q;
    logic signed [31:0] r_rd;
    logic               r_full_drop;

    logic               r_out_valid;
    logic               r_out_found;
    logic signed [31:0] r_out_rd;
    logic               r_out_status;
    logic [CNT_W-1:0]   r_out_cnt;

    logic [CNT_W-1:0]   w_idx_inc;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [ADDR_W-1:0]  w_wr_addr;
    logic               w_rd_en;
    logic               w_key_we;
    logic               w_val_we;
    logic signed [31:0] w_key_wd;
    logic signed [31:0] w_val_wd;
    logic               w_full;
    logic [CNT_W+4:0]   w_cnt_ext;

    assign w_idx_inc = r_idx + CNT_W'(1);
    assign w_full    = (r_cnt == CNT_W'(CAPACITY));
    assign w_rd_en   = i_cmd.rd_scan | i_cmd.rd_shift;
    assign w_rd_addr = i_cmd.rd_shift ? w_idx_inc[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign w_wr_addr = i_cmd.wr_append ? r_cnt[ADDR_W-1:0] : r_idx[ADDR_W-1:0];
    assign w_key_we  = i_cmd.wr_append | i_cmd.wr_shift;
    assign w_val_we  = i_cmd.wr_append | i_cmd.wr_shift | i_cmd.wr_value;
    assign w_key_wd  = i_cmd.wr_shift ? r_key_q : r_key;
    assign w_val_wd  = i_cmd.wr_shift ? r_val_q : r_value;

    // Pair memories, one write and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (w_key_we) begin
            r_key_mem[w_wr_addr] <= w_key_wd;
        end
        if (w_val_we) begin
            r_val_mem[w_wr_addr] <= w_val_wd;
        end
        if (w_rd_en) begin
            r_key_q <= r_key_mem[w_rd_addr];
            r_val_q <= r_val_mem[w_rd_addr];
        end
    end

    // Request capture and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type <= i_req_type;
            r_key      <= i_key;
            r_value    <= i_value;
        end
        if (i_cmd.decide) begin
            r_rd        <= (r_req_type == REQ_LOOKUP && r_hit) ? r_val_q : 32'sd0;
            r_full_drop <= (r_req_type == REQ_PUT) && !r_hit && w_full;
        end
        if (i_cmd.load_out) begin
            r_out_found  <= r_hit;
            r_out_rd     <= r_rd;
            r_out_status <= r_full_drop;
            r_out_cnt    <= r_cnt;
        end
    end

    // Index, count, hit flag and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cnt       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_req) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.inc_idx) begin
                r_idx <= w_idx_inc;
            end
            if (i_cmd.set_hit) begin
                r_hit <= 1'b1;
            end
            if (i_cmd.wr_append) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_cmd.dec_cnt) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.idx_at_count = (r_idx == r_cnt);
        o_sts.key_match    = (r_key_q == r_key);
        o_sts.shift_last   = (w_idx_inc == r_cnt);
        o_sts.table_full   = w_full;
        o_sts.hit          = r_hit;
        o_sts.out_free     = !r_out_valid || !i_out_stall;
        o_sts.req_type     = r_req_type;
    end

    assign w_cnt_ext     = {5'd0, r_out_cnt};
    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_read_value  = r_out_rd;
    assign o_status      = r_out_status;
    assign o_entry_count = w_cnt_ext[4:0];

endmodule

@@ design/ikvt_controller.sv @@
// Controller: sequences scan, update, shift and result hand-off.
module ikvt_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ikvt_pkg::t_dp_sts i_sts,
    output ikvt_pkg::t_dp_cmd o_cmd
);
    import ikvt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                if (i_sts.idx_at_count) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state       = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP: begin
                if (i_sts.key_match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = ST_DECIDE;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = ST_SCAN_RD;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_DONE;
                if (i_sts.req_type == REQ_PUT) begin
                    if (i_sts.hit) begin
                        o_cmd.wr_value = 1'b1;
                    end else if (!i_sts.table_full) begin
                        o_cmd.wr_append = 1'b1;
                    end
                end else if (i_sts.req_type == REQ_REMOVE && i_sts.hit) begin
                    n_state = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD: begin
                if (i_sts.shift_last) begin
                    o_cmd.dec_cnt = 1'b1;
                    n_state       = ST_DONE;
                end else begin
                    o_cmd.rd_shift = 1'b1;
                    n_state        = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.inc_idx  = 1'b1;
                n_state        = ST_SHIFT_RD;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ design/int_key_value_table.sv @@
// Top level of the linear-search key/value table.
// Each request scans the pairs from the start, stopping at a matching key or at the pair count;
// one read port, so each entry is read, then compared. A remove that hits then shifts the
// later pairs down one place before the result is offered.
// Throughput: one request at a time, next taken the cycle after the result is registered.
// Reset clears the pair count, the controller and the output valid, not the pair memories.
module int_key_value_table #(
    parameter int CAPACITY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_found,
    output logic signed [31:0] o_read_value,
    output logic               o_status,
    output logic [4:0]         o_entry_count
);
    import ikvt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The FSM walks the table one entry at a time (read, then compare),
    // applies the update, and parks the result until the output slot is free.
    ikvt_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Memories, scan index, pair count and the output register live here.
    ikvt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_value       (i_value),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_found       (o_found),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule

@@ design/ikvt_checker.sv @@
// Port-level checker for the key/value table, with its bind.
`include "int_key_value_table_defines.svh"

module ikvt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_found,
    input logic signed [31:0] o_read_value,
    input logic               o_status
);
    // A result held under stall stays up.
    `IKVT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")

    // A dropped put never reports a hit.
    `IKVT_ASSERT_NOW(a_drop_miss, i_clk, i_rst_n, o_out_valid && o_status, !o_found, "drop flagged on a hit")

    // A nonzero read value only comes from a hit.
    `IKVT_ASSERT_NOW(a_rd_hit, i_clk, i_rst_n, o_out_valid && (o_read_value != 32'sd0), o_found, "read value without hit")

    // An accepted request blocks the next one until its result is loaded.
    `IKVT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "second request taken while busy")

endmodule

bind int_key_value_table ikvt_checker u_ikvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_found       (o_found),
    .o_read_value  (o_read_value),
    .o_status      (o_status)
);
